/* src/suvm_pkg.sv */
package suvm_pkg;

  // Field widths of the vertex and texture coordinate items.
  localparam int COORD_BITS = 16;
  localparam int UV_BITS    = 16;

  // Normalization puts the largest magnitude at or above 2^NORM_MSB.
  localparam int NORM_MSB = 30;
  localparam int SHIFT_W  = $clog2(NORM_MSB + 1);

  // Scaled coordinates: magnitude up to 2^31, so 33 bits signed.
  localparam int SW = NORM_MSB + 3;
  localparam int MW = SW - 1;

  // Square root datapath.
  localparam int SQ_W       = 2 * MW;
  localparam int ROOT_W     = MW;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int SQRT_IW    = $clog2(SQRT_STEPS);
  localparam int SQ_SH_W    = $clog2(SQ_W);

  // CORDIC datapath: vector grows by the gain and by sqrt(3) at most.
  localparam int CORDIC_ITERS = 30;
  localparam int ITER_IW      = $clog2(CORDIC_ITERS);
  localparam int CW           = SW + 3;
  localparam int AW           = 34;
  localparam int OW           = 36;

  localparam logic signed [AW-1:0] HALF_TURN = AW'(64'd1 << 31);
  localparam logic signed [OW-1:0] HALF_OW   = OW'(64'd1 << 31);
  localparam logic signed [OW-1:0] FULL_OW   = OW'(64'd1 << 32);
  localparam logic signed [OW-1:0] UV_ROUND  = OW'(64'd1 << (31 - UV_BITS));
  localparam int                   UV_SHR    = 32 - UV_BITS;
  localparam logic [OW-1:0]        UV_MAX    = OW'((64'd1 << UV_BITS) - 64'd1);

  // atan(2^-i) in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURNS [CORDIC_ITERS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
  } suvm_in_t;

  typedef struct packed {
    logic [UV_BITS-1:0] tex_u;
    logic [UV_BITS-1:0] tex_v;
    logic               degenerate;
  } suvm_out_t;

  typedef struct packed {
    logic signed [SW-1:0] xs;
    logic signed [SW-1:0] ys;
    logic signed [SW-1:0] zs;
    logic                 deg;
  } suvm_scaled_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] res;
  } suvm_sqrt_t;

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [AW-1:0] ang;
  } suvm_cordic_t;

  function automatic logic signed [AW-1:0] atan_turn(input logic [ITER_IW-1:0] i);
    logic signed [AW-1:0] v;
    v = '0;
    if (int'(i) < CORDIC_ITERS) begin
      v = AW'(ATAN_TURNS[i]);
    end
    return v;
  endfunction

  // Clamp a turn fraction to [0, 1], round half up and saturate.
  function automatic logic [UV_BITS-1:0] to_uv(input logic signed [OW-1:0] q);
    logic signed [OW-1:0] c;
    logic [OW-1:0]        r;
    logic [UV_BITS-1:0]   res;
    c = q;
    if (c < 0) begin
      c = '0;
    end
    if (c > FULL_OW) begin
      c = FULL_OW;
    end
    r = c + UV_ROUND;
    r = r >> UV_SHR;
    if (r > UV_MAX) begin
      res = '1;
    end else begin
      res = r[UV_BITS-1:0];
    end
    return res;
  endfunction

endpackage

/* src/spherical_uv_mapper.sv */
// Spherical UV mapper: turns a vertex position into spherical texture coordinates.
// The input channel takes one vertex (pos_x, pos_y, pos_z, signed) on in_item
// at every rising edge where start is high and busy is low. busy is high only
// while reset is applied and until busy_r clears after it; after that the block
// takes a new item in every cycle, back to back.
// The result channel shows tex_u, tex_v and the degenerate flag on out_item for
// exactly one cycle, marked by out_valid. The receiver cannot stall; results
// leave in the order the items came in, one for each item.
// Throughput is one item per cycle. The result runs through the chain of
// two normalization stages, a squaring stage, a sum stage, 32 square-root cells
// (one root bit each), one pre-rotation stage, 30 CORDIC cells for the vertical
// angle and the output register. The horizontal angle runs through its own 30
// CORDIC cells in parallel with the root and waits in a delay line.
// Reset clears the valid pipeline, so items in flight at reset are dropped and
// no stray result appears afterwards.
module spherical_uv_mapper (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  suvm_pkg::suvm_in_t  in_item,
  output logic                out_valid,
  output suvm_pkg::suvm_out_t out_item
);
  import suvm_pkg::*;

  // Pipeline positions, counted in registers after the accepting edge.
  localparam int SQRT_END = 3 + SQRT_STEPS;
  localparam int V_END    = SQRT_END + 1 + CORDIC_ITERS;
  localparam int U_END    = 2 + CORDIC_ITERS;
  localparam int U_DLY    = V_END - U_END;
  localparam int Y_DLY    = SQRT_END - 1;
  localparam int DEG_DLY  = V_END - 1;
  // The output register sits one position after the last vertical cell.
  localparam int LAT      = V_END + 2;

  // The CORDIC works on the right half plane. A vector in the left half is
  // mirrored through the origin, and the angle starts at plus or minus half
  // a turn to make up for it.
  function automatic suvm_cordic_t cordic_pre(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b);
    suvm_cordic_t p;
    p.a   = a;
    p.b   = b;
    p.ang = '0;
    if (a < 0) begin
      p.ang = (b >= 0) ? HALF_TURN : -HALF_TURN;
      p.a   = -a;
      p.b   = -b;
    end
    return p;
  endfunction

  logic                 busy_r, busy_nxt;
  logic [LAT-1:0]       vld_r, vld_nxt;
  logic                 in_acc;

  suvm_scaled_t         scaled;
  logic [MW-1:0]        mag_x, mag_z;
  logic [SQ_W-1:0]      sq_x_r, sq_z_r, n_r;
  logic signed [SW-1:0] y_dly_r [Y_DLY];
  logic                 deg_dly_r [DEG_DLY];
  logic signed [AW-1:0] u_dly_r [U_DLY];

  suvm_cordic_t         u_pre_r, u_pre_nxt;
  suvm_cordic_t         v_pre_r, v_pre_nxt;
  suvm_cordic_t         u_bus [CORDIC_ITERS+1];
  suvm_cordic_t         v_bus [CORDIC_ITERS+1];
  suvm_sqrt_t           sqrt_bus [SQRT_STEPS+1];
  logic [ROOT_W-1:0]    root;

  logic signed [OW-1:0] uq, vq;
  suvm_out_t            out_r, out_nxt;

  // Control: the pipeline never stalls, so only the valid bits and busy need a reset.
  assign in_acc = start && !busy_r;

  always_comb begin
    busy_nxt = 1'b0;
    vld_nxt  = {vld_r[LAT-2:0], in_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      vld_r  <= vld_nxt;
    end
  end

  // Normalization: common power-of-two scale for all three coordinates.
  suvm_norm u_norm (
    .clk     (clk),
    .in_item (in_item),
    .scaled  (scaled)
  );

  // Squares for the radius in the xz plane, and the horizontal pre-rotation.
  always_comb begin
    mag_x     = scaled.xs[SW-1] ? MW'(-scaled.xs) : MW'(scaled.xs);
    mag_z     = scaled.zs[SW-1] ? MW'(-scaled.zs) : MW'(scaled.zs);
    u_pre_nxt = cordic_pre(CW'(scaled.xs), CW'(scaled.zs));
  end

  always_ff @(posedge clk) begin
    sq_x_r  <= SQ_W'(mag_x) * SQ_W'(mag_x);
    sq_z_r  <= SQ_W'(mag_z) * SQ_W'(mag_z);
    u_pre_r <= u_pre_nxt;
    n_r     <= sq_x_r + sq_z_r;
  end

  // Horizontal angle atan2(z, x).
  assign u_bus[0] = u_pre_r;

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_u_cell
    suvm_cordic_cell u_cell (
      .clk   (clk),
      .step  (ITER_IW'(i)),
      .d_in  (u_bus[i]),
      .d_out (u_bus[i+1])
    );
  end

  // Integer square root of x^2 + z^2, one root bit per cell.
  assign sqrt_bus[0].rem = n_r;
  assign sqrt_bus[0].res = '0;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt_cell
    suvm_sqrt_cell u_cell (
      .clk   (clk),
      .step  (SQRT_IW'(j)),
      .d_in  (sqrt_bus[j]),
      .d_out (sqrt_bus[j+1])
    );
  end

  assign root = sqrt_bus[SQRT_STEPS].res[ROOT_W-1:0];

  // Vertical angle atan2(y, r); r is never negative.
  always_comb begin
    v_pre_nxt = cordic_pre(CW'(root), CW'(y_dly_r[Y_DLY-1]));
  end

  always_ff @(posedge clk) begin
    v_pre_r <= v_pre_nxt;
  end

  assign v_bus[0] = v_pre_r;

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_v_cell
    suvm_cordic_cell u_cell (
      .clk   (clk),
      .step  (ITER_IW'(i)),
      .d_in  (v_bus[i]),
      .d_out (v_bus[i+1])
    );
  end

  // Delay lines that keep y, the zero-vector flag and the horizontal angle
  // in step with the slower vertical path.
  always_ff @(posedge clk) begin
    y_dly_r[0]   <= scaled.ys;
    deg_dly_r[0] <= scaled.deg;
    u_dly_r[0]   <= u_bus[CORDIC_ITERS].ang;
    for (int k = 1; k < Y_DLY; k++) begin
      y_dly_r[k] <= y_dly_r[k-1];
    end
    for (int k = 1; k < DEG_DLY; k++) begin
      deg_dly_r[k] <= deg_dly_r[k-1];
    end
    for (int k = 1; k < U_DLY; k++) begin
      u_dly_r[k] <= u_dly_r[k-1];
    end
  end

  // Output: u = 1/2 + angle_u, v = 1/2 - 2 * angle_v, both in turns.
  always_comb begin
    uq = HALF_OW + OW'(u_dly_r[U_DLY-1]);
    vq = HALF_OW - (OW'(v_bus[CORDIC_ITERS].ang) <<< 1);
    if (deg_dly_r[DEG_DLY-1]) begin
      out_nxt.tex_u      = '0;
      out_nxt.tex_v      = '0;
      out_nxt.degenerate = 1'b1;
    end else begin
      out_nxt.tex_u      = to_uv(uq);
      out_nxt.tex_v      = to_uv(vq);
      out_nxt.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = vld_r[LAT-1];
  assign out_item  = out_r;

  // Every result goes back to an item that was accepted earlier.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without an item accepted at the expected latency");

  // The degenerate flag must follow the zero-vector test of the same item.
  a_deg_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.degenerate ==
                   $past(in_item.pos_x == '0 && in_item.pos_y == '0 &&
                         in_item.pos_z == '0, LAT)))
    else $error("degenerate flag does not match its item");

  // The root of a sum below 2^64 fits in the lower half of the root register.
  a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SQRT_END] |-> (sqrt_bus[SQRT_STEPS].res[SQ_W-1:ROOT_W] == '0))
    else $error("square root result overflows its width");

endmodule

/* src/suvm_norm.sv */
module suvm_norm (
  input  logic                  clk,
  input  suvm_pkg::suvm_in_t    in_item,
  output suvm_pkg::suvm_scaled_t scaled
);
  import suvm_pkg::*;

  logic signed [COORD_BITS-1:0] x_r, y_r, z_r;
  logic [COORD_BITS-1:0]        m_r, m_nxt;
  logic                         zero_r, zero_nxt;
  logic [COORD_BITS-1:0]        mag_x, mag_y, mag_z;
  logic [SHIFT_W-1:0]           shift;
  suvm_scaled_t                 scaled_r, scaled_nxt;

  // First stage: largest magnitude of the three coordinates and the zero-vector flag.
  always_comb begin
    mag_x = in_item.pos_x[COORD_BITS-1] ? COORD_BITS'(-in_item.pos_x) : in_item.pos_x;
    mag_y = in_item.pos_y[COORD_BITS-1] ? COORD_BITS'(-in_item.pos_y) : in_item.pos_y;
    mag_z = in_item.pos_z[COORD_BITS-1] ? COORD_BITS'(-in_item.pos_z) : in_item.pos_z;
    m_nxt = mag_x;
    if (mag_y > m_nxt) begin
      m_nxt = mag_y;
    end
    if (mag_z > m_nxt) begin
      m_nxt = mag_z;
    end
    zero_nxt = (in_item.pos_x == '0) && (in_item.pos_y == '0) && (in_item.pos_z == '0);
  end

  // Second stage: shift all three by the same amount so that the
  // leading one of the largest magnitude lands at or above bit 30.
  always_comb begin
    shift = '0;
    for (int i = 0; i < COORD_BITS; i++) begin
      if (m_r[i]) begin
        shift = (i >= NORM_MSB) ? '0 : SHIFT_W'(NORM_MSB - i);
      end
    end
    scaled_nxt.xs  = SW'(x_r) <<< shift;
    scaled_nxt.ys  = SW'(y_r) <<< shift;
    scaled_nxt.zs  = SW'(z_r) <<< shift;
    scaled_nxt.deg = zero_r;
  end

  always_ff @(posedge clk) begin
    x_r      <= in_item.pos_x;
    y_r      <= in_item.pos_y;
    z_r      <= in_item.pos_z;
    m_r      <= m_nxt;
    zero_r   <= zero_nxt;
    scaled_r <= scaled_nxt;
  end

  assign scaled = scaled_r;

endmodule

/* src/suvm_sqrt_cell.sv */
module suvm_sqrt_cell (
  input  logic                         clk,
  input  logic [suvm_pkg::SQRT_IW-1:0] step,
  input  suvm_pkg::suvm_sqrt_t         d_in,
  output suvm_pkg::suvm_sqrt_t         d_out
);
  import suvm_pkg::*;

  logic [SQ_SH_W-1:0] sh;
  logic [SQ_W-1:0]    bit_w;
  logic [SQ_W-1:0]    trial;
  suvm_sqrt_t         st_r, st_nxt;

  // One root bit per cell; the trial bit walks down two places per step.
  always_comb begin
    sh    = SQ_SH_W'(SQ_W - 2) - SQ_SH_W'({step, 1'b0});
    bit_w = SQ_W'(1) << sh;
    trial = d_in.res + bit_w;
    if (d_in.rem >= trial) begin
      st_nxt.rem = d_in.rem - trial;
      st_nxt.res = (d_in.res >> 1) + bit_w;
    end else begin
      st_nxt.rem = d_in.rem;
      st_nxt.res = d_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign d_out = st_r;

endmodule

/* src/suvm_cordic_cell.sv */
module suvm_cordic_cell (
  input  logic                         clk,
  input  logic [suvm_pkg::ITER_IW-1:0] step,
  input  suvm_pkg::suvm_cordic_t       d_in,
  output suvm_pkg::suvm_cordic_t       d_out
);
  import suvm_pkg::*;

  logic signed [CW-1:0] a, b, da, db;
  logic signed [AW-1:0] rot;
  suvm_cordic_t         st_r, st_nxt;

  // One vectoring micro-rotation: drive the second component toward zero.
  always_comb begin
    a   = d_in.a;
    b   = d_in.b;
    da  = b >>> step;
    db  = a >>> step;
    rot = atan_turn(step);
    if (b >= 0) begin
      st_nxt.a   = a + da;
      st_nxt.b   = b - db;
      st_nxt.ang = d_in.ang + rot;
    end else begin
      st_nxt.a   = a - da;
      st_nxt.b   = b + db;
      st_nxt.ang = d_in.ang - rot;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign d_out = st_r;

endmodule
